// ===== rtl/tlc_pkg.sv =====
// Shared types and constants for the two-level cache controller.
// No dependencies; every rtl file refers to it by scoped names.
package tlc_pkg;

  localparam int WORD_BYTES = 4;

  localparam logic [1:0] CMD_READ  = 2'd0;
  localparam logic [1:0] CMD_WRITE = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;

  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_L1_READ   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_L1_WRITE  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_L2_READ   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_L2_WRITE  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MEM_READ  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MEM_WRITE = 3'd5;

  typedef enum logic [2:0] {
    OP_READ,
    OP_WRITE,
    OP_CLEAR,
    OP_RANGE,
    OP_NOP
  } op_e;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [31:0] address;
    logic [31:0] write_word;
  } req_t;

  typedef struct packed {
    logic [31:0] read_word;
    logic        l1_hit;
    logic        l2_hit;
    logic        range_error;
    logic [31:0] elapsed_time;
  } rsp_t;

  typedef struct packed {
    op_e         op;
    logic [31:0] address;
    logic [31:0] write_word;
  } item_t;

  typedef struct packed {
    logic [15:0] l1_read;
    logic [15:0] l1_write;
    logic [15:0] l2_read;
    logic [15:0] l2_write;
    logic [15:0] mem_read;
    logic [15:0] mem_write;
  } cost_t;

endpackage

// ===== rtl/tlc_front.sv =====
// Request front end: accepts requests and classifies them into operations.
// Depends on tlc_pkg.
module tlc_front #(
  parameter int MEM_BYTES = 1048576
) (
  input  logic          start_i,
  input  tlc_pkg::req_t req_i,
  input  logic          full_i,
  output logic          busy_o,
  output logic          push_o,
  output tlc_pkg::item_t item_o
);

  logic out_of_range;

  assign out_of_range = ({1'b0, req_i.address} >= 33'(MEM_BYTES));
  assign busy_o = full_i;
  assign push_o = start_i && !full_i;

  always_comb begin
    item_o.address    = req_i.address;
    item_o.write_word = req_i.write_word;
    unique case (req_i.cmd)
      tlc_pkg::CMD_READ:  item_o.op = out_of_range ? tlc_pkg::OP_RANGE : tlc_pkg::OP_READ;
      tlc_pkg::CMD_WRITE: item_o.op = out_of_range ? tlc_pkg::OP_RANGE : tlc_pkg::OP_WRITE;
      tlc_pkg::CMD_CLEAR: item_o.op = tlc_pkg::OP_CLEAR;
      default:            item_o.op = tlc_pkg::OP_NOP;
    endcase
  end

endmodule

// ===== rtl/tlc_fifo.sv =====
// Two-entry request queue between front end and back end.
// Depends on tlc_pkg.
module tlc_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  tlc_pkg::item_t item_i,
  input  logic           pop_i,
  output logic           full_o,
  output logic           empty_o,
  output tlc_pkg::item_t item_o
);

  tlc_pkg::item_t ent_q [2];
  logic           wr_ptr_q, wr_ptr_d;
  logic           rd_ptr_q, rd_ptr_d;
  logic [1:0]     cnt_q, cnt_d;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign item_o  = ent_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q ^ push_i;
    rd_ptr_d = rd_ptr_q ^ pop_i;
    cnt_d    = cnt_q + 2'(push_i) - 2'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      ent_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

// ===== rtl/tlc_back.sv =====
// Back end: cache arrays, backing memory, miss sequencer and time accounting.
// Depends on tlc_pkg; fed from tlc_fifo.
module tlc_back #(
  parameter int L1_LINE_COUNT = 256,
  parameter int L2_SET_COUNT  = 256,
  parameter int BLOCK_BYTES   = 64,
  parameter int MEM_BYTES     = 1048576
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  tlc_pkg::cost_t cost_i,
  input  logic           empty_i,
  input  tlc_pkg::item_t item_i,
  output logic           pop_o,
  output logic           rsp_valid_o,
  output tlc_pkg::rsp_t  rsp_o
);

  localparam int OB    = $clog2(BLOCK_BYTES);
  localparam int WBITS = OB - $clog2(tlc_pkg::WORD_BYTES);
  localparam int BW    = 1 << WBITS;
  localparam int MAW   = $clog2(MEM_BYTES);
  localparam int MWW   = MAW - $clog2(tlc_pkg::WORD_BYTES);
  localparam int BNW   = MAW - OB;
  localparam int IB1   = $clog2(L1_LINE_COUNT);
  localparam int IB2   = $clog2(L2_SET_COUNT);
  localparam int T1    = (BNW > IB1) ? BNW - IB1 : 1;
  localparam int T2    = (BNW > IB2) ? BNW - IB2 : 1;
  localparam int MEM_WORDS = MEM_BYTES / tlc_pkg::WORD_BYTES;

  localparam logic [3:0] S_CLEAR  = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_LOOK1  = 4'd2;
  localparam logic [3:0] S_L2REQ  = 4'd3;
  localparam logic [3:0] S_L2LOOK = 4'd4;
  localparam logic [3:0] S_WBK    = 4'd5;
  localparam logic [3:0] S_FILL   = 4'd6;
  localparam logic [3:0] S_L1TOL2 = 4'd7;
  localparam logic [3:0] S_TOL1   = 4'd8;
  localparam logic [3:0] S_WORD   = 4'd9;
  localparam logic [3:0] S_RDONE  = 4'd10;

  typedef struct packed {
    logic          v;
    logic          d;
    logic [T1-1:0] tag;
  } l1m_t;

  typedef struct packed {
    logic          v;
    logic          d;
    logic [T2-1:0] tag;
  } l2w_t;

  typedef struct packed {
    logic       lru;
    l2w_t [1:0] way;
  } l2m_t;

  // storage
  logic [31:0] l1d_mem [L1_LINE_COUNT*BW];
  l1m_t        l1m_mem [L1_LINE_COUNT];
  logic [31:0] l2d_mem [L2_SET_COUNT*2*BW];
  l2m_t        l2m_mem [L2_SET_COUNT];
  logic [31:0] bk_mem  [MEM_WORDS];

  logic [IB1+WBITS-1:0]   l1d_ra, l1d_wa;
  logic [IB1-1:0]         l1m_ra, l1m_wa;
  logic [IB2+WBITS:0]     l2d_ra, l2d_wa;
  logic [IB2-1:0]         l2m_ra, l2m_wa;
  logic [MWW-1:0]         bk_ra, bk_wa;
  logic                   l1d_we, l1m_we, l2d_we, l2m_we, bk_we;
  logic [31:0]            l1d_wd, l2d_wd, bk_wd;
  l1m_t                   l1m_wd;
  l2m_t                   l2m_wd;
  logic [31:0]            l1d_rd, l2d_rd, bk_rd;
  l1m_t                   l1m_rd;
  l2m_t                   l2m_rd;

  // control and item registers
  logic [3:0]       state_q, state_d;
  logic [MWW-1:0]   clr_q, clr_d;
  logic [WBITS:0]   cnt_q, cnt_d;
  logic             phase_b_q, phase_b_d;
  logic [31:0]      elapsed_q, elapsed_d;
  logic             res_valid_q, res_valid_d;
  tlc_pkg::rsp_t    res_q, res_d;
  tlc_pkg::op_e     op_q, op_d;
  logic [MAW-1:0]   addr_q, addr_d;
  logic [31:0]      data_q, data_d;
  l1m_t             m1_q, m1_d;
  logic [BNW-1:0]   cur_bn_q, cur_bn_d;
  logic [BNW-1:0]   vic_bn_q, vic_bn_d;
  logic             cur_way_q, cur_way_d;
  logic             a_way_q, a_way_d;
  logic             need_fill_q, need_fill_d;
  logic             h2_q, h2_d;

  // address fields
  logic [BNW-1:0]   blk, hd_blk;
  logic [IB1-1:0]   line, hd_line;
  logic [WBITS-1:0] word, hd_word;
  logic [T1-1:0]    tag1;
  logic [IB2-1:0]   set_a, cur_set;
  logic [T2-1:0]    cur_tag;

  assign blk     = addr_q[MAW-1:OB];
  assign line    = IB1'(blk);
  assign word    = addr_q[OB-1:OB-WBITS];
  assign tag1    = T1'(blk >> IB1);
  assign hd_blk  = item_i.address[MAW-1:OB];
  assign hd_line = IB1'(hd_blk);
  assign hd_word = item_i.address[OB-1:OB-WBITS];
  assign set_a   = IB2'(blk);
  assign cur_set = IB2'(cur_bn_q);
  assign cur_tag = T2'(cur_bn_q >> IB2);

  // block copy counter: read word k while writing word k-1
  logic [WBITS-1:0] rd_idx, wr_idx;
  logic             wr_go, cp_done;
  logic [WBITS:0]   cnt_m1;

  assign cnt_m1  = cnt_q - 1'b1;
  assign rd_idx  = cnt_q[WBITS-1:0];
  assign wr_idx  = cnt_m1[WBITS-1:0];
  assign wr_go   = (cnt_q != '0);
  assign cp_done = (cnt_q == (WBITS+1)'(BW));

  logic       hit1, hit0w, hit1w, l2hit, way, vdirty, go_after;
  l2w_t       vic;
  l2m_t       row;
  logic [17:0] inc;
  logic [3:0] after_st;

  assign pop_o       = (state_q == S_IDLE) && !empty_i;
  assign rsp_valid_o = res_valid_q;
  assign rsp_o       = res_q;

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    cnt_d       = '0;
    phase_b_d   = phase_b_q;
    elapsed_d   = elapsed_q;
    res_valid_d = 1'b0;
    res_d       = res_q;
    op_d        = op_q;
    addr_d      = addr_q;
    data_d      = data_q;
    m1_d        = m1_q;
    cur_bn_d    = cur_bn_q;
    vic_bn_d    = vic_bn_q;
    cur_way_d   = cur_way_q;
    a_way_d     = a_way_q;
    need_fill_d = need_fill_q;
    h2_d        = h2_q;
    go_after    = 1'b0;

    l1m_ra = (state_q == S_IDLE) ? hd_line : line;
    l1d_ra = (state_q == S_IDLE) ? {hd_line, hd_word} : {line, word};
    l2d_ra = {cur_set, cur_way_q, rd_idx};
    l2m_ra = cur_set;
    bk_ra  = {cur_bn_q, rd_idx};

    l1d_we = 1'b0; l1d_wa = {line, word};      l1d_wd = data_q;
    l1m_we = 1'b0; l1m_wa = line;              l1m_wd = '{v: 1'b1, d: 1'b0, tag: tag1};
    l2d_we = 1'b0; l2d_wa = {cur_set, cur_way_q, wr_idx}; l2d_wd = bk_rd;
    l2m_we = 1'b0; l2m_wa = cur_set;           l2m_wd = l2m_rd;
    bk_we  = 1'b0; bk_wa  = {vic_bn_q, wr_idx}; bk_wd = l2d_rd;

    hit1  = l1m_rd.v && (l1m_rd.tag == tag1);
    row   = l2m_rd;
    hit0w = row.way[0].v && (row.way[0].tag == cur_tag);
    hit1w = row.way[1].v && (row.way[1].tag == cur_tag);
    l2hit = hit0w || hit1w;
    way   = hit0w ? 1'b0 : (hit1w ? 1'b1 : row.lru);
    vic   = row.way[way];
    vdirty = !l2hit && vic.v && vic.d;
    inc   = 18'(phase_b_q ? cost_i.l2_write : cost_i.l2_read)
          + (l2hit ? 18'd0 : 18'(cost_i.mem_read))
          + (vdirty ? 18'(cost_i.mem_write) : 18'd0);

    if (phase_b_q) begin
      after_st = S_L1TOL2;
    end else if (m1_q.v && m1_q.d) begin
      after_st = S_L2REQ;
    end else begin
      after_st = S_TOL1;
    end

    unique case (state_q)
      S_CLEAR: begin
        bk_we  = 1'b1; bk_wa  = clr_q;            bk_wd  = '0;
        l1m_we = 1'b1; l1m_wa = clr_q[IB1-1:0];   l1m_wd = '0;
        l2m_we = 1'b1; l2m_wa = clr_q[IB2-1:0];   l2m_wd = '0;
        clr_d  = clr_q + 1'b1;
        if (clr_q == '1) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (!empty_i) begin
          op_d   = item_i.op;
          addr_d = item_i.address[MAW-1:0];
          data_d = item_i.write_word;
          res_d  = '0;
          res_d.elapsed_time = elapsed_q;
          case (item_i.op) inside
            tlc_pkg::OP_CLEAR: begin
              elapsed_d          = '0;
              res_d.elapsed_time = '0;
              res_valid_d        = 1'b1;
            end
            tlc_pkg::OP_RANGE: begin
              res_d.range_error = 1'b1;
              res_valid_d       = 1'b1;
            end
            tlc_pkg::OP_READ, tlc_pkg::OP_WRITE: begin
              state_d = S_LOOK1;
            end
            default: begin
              res_valid_d = 1'b1;
            end
          endcase
        end
      end
      S_LOOK1: begin
        if (hit1) begin
          res_d.l1_hit = 1'b1;
          if (op_q == tlc_pkg::OP_READ) begin
            res_d.read_word = l1d_rd;
            elapsed_d       = elapsed_q + 32'(cost_i.l1_read);
          end else begin
            l1d_we    = 1'b1;
            l1m_we    = 1'b1;
            l1m_wd.d  = 1'b1;
            elapsed_d = elapsed_q + 32'(cost_i.l1_write);
          end
          res_d.elapsed_time = elapsed_d;
          res_valid_d        = 1'b1;
          state_d            = S_IDLE;
        end else begin
          m1_d      = l1m_rd;
          cur_bn_d  = blk;
          phase_b_d = 1'b0;
          state_d   = S_L2REQ;
        end
      end
      S_L2REQ: begin
        state_d = S_L2LOOK;
      end
      S_L2LOOK: begin
        l2m_we     = 1'b1;
        l2m_wd     = row;
        l2m_wd.lru = ~way;
        if (!l2hit) begin
          l2m_wd.way[way] = '{v: 1'b1, d: 1'b0, tag: cur_tag};
        end
        if (phase_b_q) begin
          l2m_wd.way[way].d = 1'b1;
        end else begin
          h2_d    = l2hit;
          a_way_d = way;
        end
        elapsed_d   = elapsed_q + 32'(inc);
        cur_way_d   = way;
        vic_bn_d    = BNW'({vic.tag, cur_set});
        need_fill_d = !l2hit && !phase_b_q;
        if (vdirty) begin
          state_d = S_WBK;
        end else if (!l2hit && !phase_b_q) begin
          state_d = S_FILL;
        end else begin
          go_after = 1'b1;
        end
      end
      S_WBK: begin
        bk_we = wr_go;
        cnt_d = cnt_q + 1'b1;
        if (cp_done) begin
          cnt_d = '0;
          if (need_fill_q) begin
            state_d = S_FILL;
          end else begin
            go_after = 1'b1;
          end
        end
      end
      S_FILL: begin
        l2d_we = wr_go;
        cnt_d  = cnt_q + 1'b1;
        if (cp_done) begin
          cnt_d    = '0;
          go_after = 1'b1;
        end
      end
      S_L1TOL2: begin
        l1d_ra = {line, rd_idx};
        l2d_we = wr_go;
        l2d_wd = l1d_rd;
        cnt_d  = cnt_q + 1'b1;
        if (cp_done) begin
          cnt_d   = '0;
          state_d = S_TOL1;
        end
      end
      S_TOL1: begin
        l2d_ra = {set_a, a_way_q, rd_idx};
        l1d_we = wr_go;
        l1d_wa = {line, wr_idx};
        l1d_wd = l2d_rd;
        cnt_d  = cnt_q + 1'b1;
        if (cp_done) begin
          cnt_d   = '0;
          state_d = S_WORD;
        end
      end
      S_WORD: begin
        l1m_we   = 1'b1;
        l1m_wd.d = (op_q == tlc_pkg::OP_WRITE);
        if (op_q == tlc_pkg::OP_WRITE) begin
          l1d_we             = 1'b1;
          elapsed_d          = elapsed_q + 32'(cost_i.l1_write);
          res_d.l2_hit       = h2_q;
          res_d.elapsed_time = elapsed_d;
          res_valid_d        = 1'b1;
          state_d            = S_IDLE;
        end else begin
          state_d = S_RDONE;
        end
      end
      S_RDONE: begin
        elapsed_d          = elapsed_q + 32'(cost_i.l1_read);
        res_d.read_word    = l1d_rd;
        res_d.l2_hit       = h2_q;
        res_d.elapsed_time = elapsed_d;
        res_valid_d        = 1'b1;
        state_d            = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    // second-level work done: next comes the dirty-victim pass or the line copy
    if (go_after) begin
      state_d = after_st;
      if (!phase_b_q && m1_q.v && m1_q.d) begin
        phase_b_d = 1'b1;
        cur_bn_d  = BNW'({m1_q.tag, line});
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      cnt_q       <= '0;
      phase_b_q   <= 1'b0;
      elapsed_q   <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      cnt_q       <= cnt_d;
      phase_b_q   <= phase_b_d;
      elapsed_q   <= elapsed_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q       <= res_d;
    op_q        <= op_d;
    addr_q      <= addr_d;
    data_q      <= data_d;
    m1_q        <= m1_d;
    cur_bn_q    <= cur_bn_d;
    vic_bn_q    <= vic_bn_d;
    cur_way_q   <= cur_way_d;
    a_way_q     <= a_way_d;
    need_fill_q <= need_fill_d;
    h2_q        <= h2_d;
  end

  always_ff @(posedge clk_i) begin
    if (l1d_we) begin
      l1d_mem[l1d_wa] <= l1d_wd;
    end
    l1d_rd <= l1d_mem[l1d_ra];
  end

  always_ff @(posedge clk_i) begin
    if (l1m_we) begin
      l1m_mem[l1m_wa] <= l1m_wd;
    end
    l1m_rd <= l1m_mem[l1m_ra];
  end

  always_ff @(posedge clk_i) begin
    if (l2d_we) begin
      l2d_mem[l2d_wa] <= l2d_wd;
    end
    l2d_rd <= l2d_mem[l2d_ra];
  end

  always_ff @(posedge clk_i) begin
    if (l2m_we) begin
      l2m_mem[l2m_wa] <= l2m_wd;
    end
    l2m_rd <= l2m_mem[l2m_ra];
  end

  always_ff @(posedge clk_i) begin
    if (bk_we) begin
      bk_mem[bk_wa] <= bk_wd;
    end
    bk_rd <= bk_mem[bk_ra];
  end

endmodule

// ===== rtl/two_level_cache_controller_top.sv =====
// A first-level hit is answered from the first-level lookup, with the result strobe
// registered after it; each block move (L2<->memory, L1<->L2) copies the block word
// by word, reading one word while writing the one before, after a second-level lookup,
// and a final word step ends the access (write or read). Clear, range-error and unused
// commands are answered straight from idle. Results cannot be stalled.
// After reset a clearing pass zeroes backing memory and
// cache tags; requests queue meanwhile (busy once two are waiting).
module two_level_cache_controller_top #(
  parameter int L1_LINE_COUNT = 256,
  parameter int L2_SET_COUNT  = 256,
  parameter int BLOCK_BYTES   = 64,
  parameter int MEM_BYTES     = 1048576
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  output logic                            busy_o,
  input  tlc_pkg::req_t                   req_i,
  output logic                            rsp_valid_o,
  output tlc_pkg::rsp_t                   rsp_o,
  input  logic                            cfg_we_i,
  input  logic [tlc_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [15:0]                     cfg_wdata_i
);

  tlc_pkg::cost_t cost_q;
  tlc_pkg::item_t front_item, head_item;
  logic           push, pop, full, empty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cost_q.l1_read   <= 16'd1;
      cost_q.l1_write  <= 16'd1;
      cost_q.l2_read   <= 16'd4;
      cost_q.l2_write  <= 16'd4;
      cost_q.mem_read  <= 16'd100;
      cost_q.mem_write <= 16'd100;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        tlc_pkg::REG_L1_READ:   cost_q.l1_read   <= cfg_wdata_i;
        tlc_pkg::REG_L1_WRITE:  cost_q.l1_write  <= cfg_wdata_i;
        tlc_pkg::REG_L2_READ:   cost_q.l2_read   <= cfg_wdata_i;
        tlc_pkg::REG_L2_WRITE:  cost_q.l2_write  <= cfg_wdata_i;
        tlc_pkg::REG_MEM_READ:  cost_q.mem_read  <= cfg_wdata_i;
        tlc_pkg::REG_MEM_WRITE: cost_q.mem_write <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  tlc_front #(
    .MEM_BYTES(MEM_BYTES)
  ) u_front (
    .start_i(start_i),
    .req_i  (req_i),
    .full_i (full),
    .busy_o (busy_o),
    .push_o (push),
    .item_o (front_item)
  );

  tlc_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .item_i (front_item),
    .pop_i  (pop),
    .full_o (full),
    .empty_o(empty),
    .item_o (head_item)
  );

  tlc_back #(
    .L1_LINE_COUNT(L1_LINE_COUNT),
    .L2_SET_COUNT (L2_SET_COUNT),
    .BLOCK_BYTES  (BLOCK_BYTES),
    .MEM_BYTES    (MEM_BYTES)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cost_i     (cost_q),
    .empty_i    (empty),
    .item_i     (head_item),
    .pop_o      (pop),
    .rsp_valid_o(rsp_valid_o),
    .rsp_o      (rsp_o)
  );

endmodule
